// ----- hw/rtl/modem_receive_frame_extractor_unit_assert.svh -----
// Assertion macros for the modem receive frame extractor.
// Used by every module that carries concurrent checks; needs clk and rst_n in scope.
`ifndef MODEM_RECEIVE_FRAME_EXTRACTOR_UNIT_ASSERT_SVH
`define MODEM_RECEIVE_FRAME_EXTRACTOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MRFE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MRFE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MRFE_ASSERT_IMP(lbl, ante, cons, msg)
`define MRFE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/mrfe_pkg.sv -----
// Shared types and constants for the modem receive frame extractor.
// No dependencies.
package mrfe_pkg;

  localparam logic [2:0] LEN_DIGITS = 3'd4;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [7:0] HDR_LIMIT_RST = 8'd50;
  localparam logic [3:0] SEP_COUNT_RST = 4'd3;

  typedef enum logic [0:0] {
    CFG_HEADER_LIMIT = 1'b0,
    CFG_SEP_COUNT    = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_LEAD   = 3'd1,
    ST_HDR_LONG  = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_TRAIL = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LEAD_LF  = 3'd1,
    PH_HEADER   = 3'd2,
    PH_LENGTH   = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_TRAIL_CR = 3'd5,
    PH_TRAIL_LF = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] header_limit;
    logic [3:0] separator_count;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [13:0] length;
  } res_t;

endpackage

// ----- hw/rtl/mrfe_parse.sv -----
// Frame parser: phase state machine, counters and the per-byte step logic.
// Depends on mrfe_pkg and the assertion macro header.
`include "modem_receive_frame_extractor_unit_assert.svh"

module mrfe_parse import mrfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic       start_req,
  input  logic [7:0] rx_byte,
  output logic       has_res,
  output res_t       res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [3:0]  commas_r, commas_nxt;
  logic [2:0]  digits_r, digits_nxt;
  logic [13:0] pay_len_r, pay_len_nxt;
  logic [13:0] pay_rem_r, pay_rem_nxt;

  logic [3:0]  need;
  logic        is_digit;
  logic        emit;
  status_t     code;

  assign need     = (cfg.separator_count == 4'd0) ? 4'd1 : cfg.separator_count;
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      hdr_cnt_r <= '0;
      commas_r  <= '0;
      digits_r  <= '0;
      pay_len_r <= '0;
      pay_rem_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      commas_r  <= commas_nxt;
      digits_r  <= digits_nxt;
      pay_len_r <= pay_len_nxt;
      pay_rem_r <= pay_rem_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    commas_nxt  = commas_r;
    digits_nxt  = digits_r;
    pay_len_nxt = pay_len_r;
    pay_rem_nxt = pay_rem_r;
    emit        = 1'b0;
    code        = ST_OK;
    has_res     = 1'b0;
    res         = '0;

    if (start_req) begin
      // a start flag resets the counters whatever the phase; a CR opens a new frame
      hdr_cnt_nxt = '0;
      commas_nxt  = '0;
      digits_nxt  = '0;
      pay_len_nxt = '0;
      pay_rem_nxt = '0;
      if (rx_byte == CH_CR) begin
        phase_nxt = PH_LEAD_LF;
      end else begin
        emit = 1'b1;
        code = ST_NO_LEAD;
      end
    end else begin
      case (phase_r)
        PH_LEAD_LF: begin
          if (rx_byte == CH_LF) begin
            phase_nxt = PH_HEADER;
          end else begin
            emit = 1'b1;
            code = ST_NO_LEAD;
          end
        end
        PH_HEADER: begin
          hdr_cnt_nxt = hdr_cnt_r + 8'd1;
          if (rx_byte == CH_COMMA) begin
            commas_nxt = commas_r + 4'd1;
          end
          if ((rx_byte == CH_COMMA) && (commas_nxt == need)) begin
            digits_nxt  = '0;
            pay_len_nxt = '0;
            phase_nxt   = PH_LENGTH;
          end else if (hdr_cnt_nxt == cfg.header_limit) begin
            // limit of zero wraps the counter, so it acts as 256
            emit = 1'b1;
            code = ST_HDR_LONG;
          end
        end
        PH_LENGTH: begin
          if (is_digit) begin
            if (digits_r >= LEN_DIGITS) begin
              emit = 1'b1;
              code = ST_BAD_LEN;
            end else begin
              pay_len_nxt = (pay_len_r << 3) + (pay_len_r << 1) + {10'd0, rx_byte[3:0]};
              digits_nxt  = digits_r + 3'd1;
            end
          end else if ((rx_byte == CH_COMMA) && (digits_r != 3'd0)) begin
            pay_rem_nxt = pay_len_r;
            phase_nxt   = (pay_len_r == 14'd0) ? PH_TRAIL_CR : PH_PAYLOAD;
          end else begin
            emit = 1'b1;
            code = ST_BAD_LEN;
          end
        end
        PH_PAYLOAD: begin
          pay_rem_nxt = pay_rem_r - 14'd1;
          if (pay_rem_nxt == 14'd0) begin
            phase_nxt = PH_TRAIL_CR;
          end
          has_res  = 1'b1;
          res.data = rx_byte;
        end
        PH_TRAIL_CR: begin
          if (rx_byte == CH_CR) begin
            phase_nxt = PH_TRAIL_LF;
          end else begin
            emit = 1'b1;
            code = ST_BAD_TRAIL;
          end
        end
        PH_TRAIL_LF: begin
          emit = 1'b1;
          code = (rx_byte == CH_LF) ? ST_OK : ST_BAD_TRAIL;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    if (emit) begin
      phase_nxt  = PH_IDLE;
      has_res    = 1'b1;
      res.kind   = 1'b1;
      res.status = code;
      res.length = pay_len_nxt;
    end
  end

  `MRFE_ASSERT_IMP(a_rem_live, phase_r == PH_PAYLOAD, pay_rem_r != 14'd0,
                   "payload phase with nothing left to pass")
  `MRFE_ASSERT_IMP(a_digits_max, 1'b1, digits_r <= LEN_DIGITS,
                   "length digit count beyond limit")
  `MRFE_ASSERT_NXT(a_status_idle, step && has_res && res.kind, phase_r == PH_IDLE,
                   "frame still open after status item")

endmodule

// ----- hw/rtl/mrfe_outreg.sv -----
// Result register: holds one result item until the output side takes it.
// Depends on mrfe_pkg.
module mrfe_outreg import mrfe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t load_res,
  input  logic out_stall,
  output logic free,
  output logic out_valid,
  output res_t out_res
);

  logic valid_r;
  res_t res_r;

  // free when empty or the held item leaves this cycle
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (free) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

endmodule

// ----- hw/rtl/modem_receive_frame_extractor_unit.sv -----
// Modem receive frame extractor: one received byte per item in, payload bytes
// and one status item per frame out. One input register, one result register.
// Depends on mrfe_pkg, mrfe_parse, mrfe_outreg and the assertion macro header.
//
// Takes one byte per clock while in_stall is low. A byte is registered on
// acceptance and parsed in the following cycle; its result, if any, is loaded
// into the result register once that register is free, raising out_valid.
// in_stall rises only while a byte that yields a result is held behind a
// result register that the output side is stalling; bytes that yield no
// result never wait. Configuration writes are always taken (cfg_ready high)
// and must be made while no frame is in flight.
`include "modem_receive_frame_extractor_unit_assert.svh"

module modem_receive_frame_extractor_unit import mrfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_req,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_data,
  output logic [2:0]  out_status,
  output logic [13:0] out_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t       cfg_r;
  logic       s1_valid_r;
  logic       s1_start_r;
  logic [7:0] s1_byte_r;
  logic       s1_adv;
  logic       has_res;
  res_t       res;
  logic       oreg_free;
  res_t       out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_limit    <= HDR_LIMIT_RST;
      cfg_r.separator_count <= SEP_COUNT_RST;
    end else if (cfg_valid && cfg_ready && (cfg_index[1] == 1'b0)) begin
      case (cfg_reg_t'(cfg_index[0]))
        CFG_HEADER_LIMIT: cfg_r.header_limit    <= cfg_data;
        CFG_SEP_COUNT:    cfg_r.separator_count <= cfg_data[3:0];
        default:          cfg_r                 <= cfg_r;
      endcase
    end
  end

  assign s1_adv   = s1_valid_r && (!has_res || oreg_free);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_start_r <= in_start_req;
      s1_byte_r  <= in_rx_byte;
    end
  end

  mrfe_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step      (s1_adv),
    .start_req (s1_start_r),
    .rx_byte   (s1_byte_r),
    .has_res   (has_res),
    .res       (res)
  );

  mrfe_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_adv && has_res),
    .load_res  (res),
    .out_stall (out_stall),
    .free      (oreg_free),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind   = out_res.kind;
  assign out_data   = out_res.data;
  assign out_status = out_res.status;
  assign out_length = out_res.length;

  `MRFE_ASSERT_IMP(a_stall_held, in_stall, s1_valid_r && has_res && out_valid,
                   "input stalled without a blocked result")
  `MRFE_ASSERT_IMP(a_byte_clean, out_valid && !out_kind,
                   out_status == 3'd0 && out_length == 14'd0,
                   "payload item carries status fields")
  `MRFE_ASSERT_IMP(a_status_clean, out_valid && out_kind, out_data == 8'd0,
                   "status item carries data")

endmodule

// ----- bench/modem_receive_frame_extractor_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for modem_receive_frame_extractor_unit: receive notices, noise and
// broken frames go in, payload and status items are predicted and checked as they leave.
// Depends on mrfe_pkg and the RTL of the unit.
module modem_receive_frame_extractor_unit_test import mrfe_pkg::*; ();

  typedef logic [7:0] byte_q_t[$];

  // Tracks the frame parser and holds the items it has yet to see.
  class frame_tracker;
    logic [7:0]  hdr_limit;
    logic [3:0]  sep_count;
    phase_t      phase;
    logic [7:0]  hdr_seen;
    logic [3:0]  commas;
    logic [2:0]  digits;
    logic [13:0] plen;
    logic [13:0] prem;
    res_t        awaited[$];
    int          errors;

    function new();
      hdr_limit = HDR_LIMIT_RST;
      sep_count = SEP_COUNT_RST;
      phase     = PH_IDLE;
      hdr_seen  = '0;
      commas    = '0;
      digits    = '0;
      plen      = '0;
      prem      = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] v);
      if (idx == 2'(CFG_HEADER_LIMIT)) hdr_limit = v;
      else if (idx == 2'(CFG_SEP_COUNT)) sep_count = v[3:0];
    endfunction

    function void give_status(status_t code);
      awaited.push_back(res_t'{1'b1, 8'd0, code, plen});
      phase = PH_IDLE;
    endfunction

    function void take_byte(logic s, logic [7:0] b);
      logic [3:0] need;
      need = (sep_count == 4'd0) ? 4'd1 : sep_count;
      if (s) begin
        hdr_seen = '0;
        commas   = '0;
        digits   = '0;
        plen     = '0;
        prem     = '0;
        if (b == CH_CR) phase = PH_LEAD_LF;
        else give_status(ST_NO_LEAD);
        return;
      end
      case (phase)
        PH_LEAD_LF: begin
          if (b == CH_LF) phase = PH_HEADER;
          else give_status(ST_NO_LEAD);
        end
        PH_HEADER: begin
          hdr_seen = hdr_seen + 8'd1;
          if (b == CH_COMMA) begin
            commas = commas + 4'd1;
            if (commas == need) begin
              digits = '0;
              plen   = '0;
              phase  = PH_LENGTH;
              return;
            end
          end
          if (hdr_seen == hdr_limit) give_status(ST_HDR_LONG);
        end
        PH_LENGTH: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            if (digits >= LEN_DIGITS) give_status(ST_BAD_LEN);
            else begin
              plen   = 14'(int'(plen) * 10 + int'(b - CH_ZERO));
              digits = digits + 3'd1;
            end
          end else if (b == CH_COMMA && digits != 3'd0) begin
            prem  = plen;
            phase = (prem == 14'd0) ? PH_TRAIL_CR : PH_PAYLOAD;
          end else begin
            give_status(ST_BAD_LEN);
          end
        end
        PH_PAYLOAD: begin
          prem = prem - 14'd1;
          if (prem == 14'd0) phase = PH_TRAIL_CR;
          awaited.push_back(res_t'{1'b0, b, 3'd0, 14'd0});
        end
        PH_TRAIL_CR: begin
          if (b == CH_CR) phase = PH_TRAIL_LF;
          else give_status(ST_BAD_TRAIL);
        end
        PH_TRAIL_LF: begin
          give_status((b == CH_LF) ? ST_OK : ST_BAD_TRAIL);
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: kind %0d data %02h status %0d length %0d",
                   got.kind, got.data, got.status, got.length);
        return;
      end
      want = awaited.pop_front();
      if (got.kind != want.kind || got.data != want.data ||
          got.status != want.status || got.length != want.length) begin
        errors++;
        if (errors <= 10)
          $display({"item mismatch (exp/got): kind %0d/%0d data %02h/%02h ",
                    "status %0d/%0d length %0d/%0d"},
                   want.kind, got.kind, want.data, got.data, want.status, got.status,
                   want.length, got.length);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_start_req = 1'b0;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  out_data;
  logic [2:0]  out_status;
  logic [13:0] out_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'd0;

  frame_tracker tracker = new();
  int           bytes_sent = 0;
  int           send_run = 0;
  logic         send_gappy = 1'b0;

  modem_receive_frame_extractor_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_start_req (in_start_req),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_data     (out_data),
    .out_status   (out_status),
    .out_length   (out_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) tracker.take_byte(in_start_req, in_rx_byte);
      if (out_valid && !out_stall)
        tracker.check_result(res_t'{out_kind, out_data, out_status, out_length});
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance, valid still high.
  task automatic push_byte(input logic s, input logic [7:0] b);
    int gap;
    if (send_run == 0) begin
      send_gappy = 1'($urandom_range(0, 1));
      send_run   = $urandom_range(8, 64);
    end
    send_run--;
    gap = send_gappy ? $urandom_range(0, 16) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= s;
    in_rx_byte   <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) push_byte(i == 0, q[i]);
    bytes_sent += q.size();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    // bytes that give no item may still be in the pipe
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= 2'(r);
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] hl, input logic [3:0] sc);
    send_bytes('{8'h00});   // closes any open frame
    drain();
    write_reg(CFG_HEADER_LIMIT, hl);
    write_reg(CFG_SEP_COUNT, {4'd0, sc});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] hdr_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_COMMA);
    return c;
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_NINE);
    return c;
  endfunction

  // Mostly well-formed notices with random content; some get one fault each.
  task automatic random_notice();
    byte_q_t fr;
    byte_q_t lf;
    int len, fault, fill, v, i;
    fault = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 8);
    case ($urandom_range(0, 49))
      0:          len = $urandom_range(100, 400);
      1, 2, 3, 4: len = $urandom_range(13, 99);
      default:    len = $urandom_range(0, 12);
    endcase
    fill = (int'(tracker.hdr_limit) - int'(tracker.sep_count)) / int'(tracker.sep_count);
    if (fill > 6) fill = 6;
    if (fill < 0) fill = 0;
    fr.push_back(CH_CR);
    fr.push_back(CH_LF);
    if (fault == 3) repeat (tracker.hdr_limit) fr.push_back(hdr_char());
    for (i = 0; i < int'(tracker.sep_count); i++) begin
      repeat ($urandom_range(0, fill)) fr.push_back(hdr_char());
      fr.push_back(CH_COMMA);
    end
    v = len;
    do begin
      lf.push_front(8'(int'(CH_ZERO) + v % 10));
      v = v / 10;
    end while (v != 0);
    while (lf.size() < 4 && $urandom_range(0, 3) == 0) lf.push_front(CH_ZERO);
    if (fault == 4) lf[$urandom_range(0, lf.size() - 1)] = non_digit();
    if (fault == 5) lf.delete();
    if (fault == 6)
      while (lf.size() < 5) lf.push_front(8'(int'(CH_ZERO) + $urandom_range(0, 9)));
    foreach (lf[j]) fr.push_back(lf[j]);
    fr.push_back(CH_COMMA);
    repeat (len) fr.push_back(8'($urandom_range(0, 255)));
    fr.push_back(CH_CR);
    fr.push_back(CH_LF);
    case (fault)
      1: fr[0] = 8'($urandom_range(0, 255));
      2: fr[1] = 8'($urandom_range(0, 255));
      7: fr[fr.size() - $urandom_range(1, 2)] = 8'($urandom_range(0, 255));
      // cut short: the next start flag restarts silently
      8: while (fr.size() > 1 && $urandom_range(0, 7) != 0) void'(fr.pop_back());
      default: ;
    endcase
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 4)) push_byte(1'b0, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 29) == 0) drain();
    send_bytes(fr);
  endtask

  initial begin : result_sink
    int hold, run;
    logic gappy;
    run = 0;
    gappy = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (run == 0) begin
        gappy = 1'($urandom_range(0, 1));
        run   = $urandom_range(8, 48);
      end
      run--;
      hold = gappy ? $urandom_range(0, 16) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("modem_receive_frame_extractor_unit_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] hl_set[7];
    logic [3:0] sc_set[7];
    int p, target;
    hl_set = '{8'd50, 8'd1, 8'd255, 8'd0, 8'd3, 8'd0, 8'd255};
    sc_set = '{4'd3, 4'd1, 4'd15, 4'd0, 4'd15, 4'd0, 4'd1};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: one comma, two header bytes at most
    write_reg(CFG_HEADER_LIMIT, 8'd2);
    write_reg(CFG_SEP_COUNT, 8'd1);
    cfg_valid <= 1'b0;
    send_bytes('{8'h00});
    send_bytes('{CH_CR, 8'hFF});
    push_byte(1'b0, 8'h7F);
    send_bytes('{CH_CR, CH_LF, CH_COMMA, CH_ZERO, CH_COMMA, CH_CR, CH_LF});
    send_bytes('{CH_CR, CH_LF, 8'h41, 8'h42});
    send_bytes('{CH_CR, CH_LF, CH_COMMA, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE});
    send_bytes('{CH_CR, CH_LF, CH_COMMA, CH_COMMA});
    send_bytes('{CH_CR, CH_LF, CH_COMMA, 8'h31, CH_COMMA, 8'hFF, CH_CR, 8'h00});
    send_bytes('{CH_CR, CH_LF, CH_COMMA});
    send_bytes('{CH_CR, CH_LF, CH_COMMA, 8'h31, CH_COMMA, CH_COMMA, CH_CR, CH_LF});

    target = bytes_sent;
    for (p = 0; p < 7; p++) begin
      if (hl_set[p] == 8'd0) hl_set[p] = 8'($urandom_range(1, 255));
      if (sc_set[p] == 4'd0) sc_set[p] = 4'($urandom_range(1, 15));
      configure(hl_set[p], sc_set[p]);
      target += 240;
      while (bytes_sent < target) random_notice();
    end

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("modem_receive_frame_extractor_unit_test: done, clean");
    else
      $display("modem_receive_frame_extractor_unit_test: done, errors");
    $finish;
  end

endmodule
